[design/tmh_pkg.sv]
// Package for the timer min-heap queue: sizes, codes, word types and helpers.
// Used by the stream interfaces and by timer_min_heap_top.
package tmh_pkg;
	localparam int HEAP_DEPTH = 64;
	localparam int ID_COUNT = 1024;
	localparam int SLOT_W = $clog2(HEAP_DEPTH);
	localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
	localparam int ID_W = 10;
	localparam int TIME_W = 32;
	localparam int WAIT_W = 24;
	localparam int KIND_W = 2;
	localparam int ACT_W = 2;

	localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIRE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ABSENT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FULL = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [ID_W-1:0] timer_id;
		logic [WAIT_W-1:0] timeout;
	} in_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0] fired_id;
		logic [WAIT_W-1:0] next_wait;
		logic queue_empty;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0] owner;
	} heap_ent_t;

	function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction
endpackage

[design/tmh_in_if.sv]
// Stream interface that carries one request word of the timer queue.
// Depends on tmh_pkg for the word type.
interface tmh_in_if;
	logic valid;
	logic ready;
	tmh_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/tmh_out_if.sv]
// Stream interface that carries one result word of the timer queue.
// Depends on tmh_pkg for the word type.
interface tmh_out_if;
	logic valid;
	logic ready;
	tmh_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/timer_min_heap_top.sv]
// Timer queue kept as a binary min-heap with an id-to-slot map, sequenced by one FSM.
// Depends on tmh_pkg, tmh_in_if and tmh_out_if.
// Add sifts the new or updated entry; fire-and-remove moves the tail entry into the freed slot
// and sifts it unless it was the tail; clear empties the heap; tick removes each expired root.
// One request at a time, ready again when its last word is offered; words wait on a stalled output.
// Reset clears the time, the count and the control state; the memories need no clearing pass.
module timer_min_heap_top (
	input logic clk,
	input logic arst_n,
	tmh_in_if.sink req,
	tmh_out_if.source rsp
);
	import tmh_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOK = 4'd1;
	localparam logic [3:0] S_CHK = 4'd2;
	localparam logic [3:0] S_REM = 4'd3;
	localparam logic [3:0] S_REMW = 4'd4;
	localparam logic [3:0] S_SRD = 4'd5;
	localparam logic [3:0] S_SCMP = 4'd6;
	localparam logic [3:0] S_TROOT = 4'd7;
	localparam logic [3:0] S_TCHK = 4'd8;
	localparam logic [3:0] S_WAIT = 4'd9;
	localparam logic [3:0] S_WAITW = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;
	localparam logic [3:0] S_EOUT = 4'd12;

	heap_ent_t heap_mem [HEAP_DEPTH];
	logic [SLOT_W-1:0] slot_mem [ID_COUNT];
	logic [ID_W-1:0] fire_mem [HEAP_DEPTH];

	logic [3:0] state_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] nfire_q;
	logic [SLOT_W-1:0] emit_q;
	logic [ACT_W-1:0] act_q;
	logic [ID_W-1:0] id_q;
	logic [WAIT_W-1:0] to_q;
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0] res_id_q;
	logic [WAIT_W-1:0] wait_q;
	logic empty_q;
	logic [SLOT_W-1:0] pos_q;
	heap_ent_t cur_q;
	logic dn_q;
	logic moved_q;
	heap_ent_t ha_q;
	heap_ent_t hb_q;
	logic [SLOT_W-1:0] sm_q;
	logic [ID_W-1:0] fb_q;
	out_word_t out_q;
	logic out_v_q;

	logic [SLOT_W-1:0] ra_addr;
	logic [SLOT_W-1:0] rb_addr;
	logic hw_en;
	logic [SLOT_W-1:0] hw_addr;
	heap_ent_t hw_data;
	logic sw_en;
	logic [ID_W-1:0] sw_addr;
	logic [SLOT_W-1:0] sw_data;

	logic [SLOT_W+1:0] l_idx;
	logic [SLOT_W+1:0] r_idx;
	logic [SLOT_W-1:0] par_idx;
	logic l_ok;
	logic r_ok;
	logic lv;
	logic rv;
	logic [TIME_W-1:0] best_exp;
	heap_ent_t child;
	logic pv;
	logic known;
	logic [TIME_W-1:0] root_d;
	logic expired;
	logic out_free;
	logic single;
	logic is_last;
	logic [3:0] after_sift;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	assign l_idx = {1'b0, pos_q, 1'b1};
	assign r_idx = l_idx + 1'b1;
	assign par_idx = (pos_q - 1'b1) >> 1;
	assign l_ok = l_idx < {1'b0, count_q};
	assign r_ok = r_idx < {1'b0, count_q};
	assign lv = l_ok && earlier(ha_q.expiry, cur_q.expiry);
	assign best_exp = lv ? ha_q.expiry : cur_q.expiry;
	assign rv = r_ok && earlier(hb_q.expiry, best_exp);
	assign child = rv ? hb_q : ha_q;
	assign pv = earlier(cur_q.expiry, ha_q.expiry);
	assign known = ({1'b0, sm_q} < count_q) && (ha_q.owner == id_q);
	assign root_d = ha_q.expiry - now_q;
	assign expired = (root_d == '0) || root_d[TIME_W-1];
	assign out_free = !out_v_q || rsp.ready;
	assign single = (act_q != ACT_TICK) || (nfire_q == '0);
	assign is_last = single || ({1'b0, emit_q} == nfire_q - 1'b1);
	assign after_sift = (act_q == ACT_TICK) ? S_TROOT : S_WAIT;

	always_comb begin
		ra_addr = '0;
		rb_addr = '0;
		case (state_q)
			S_LOOK: ra_addr = sm_q;
			S_CHK: ra_addr = sm_q;
			S_REM: ra_addr = SLOT_W'(count_q - 1'b1);
			S_SRD: begin
				ra_addr = dn_q ? l_idx[SLOT_W-1:0] : par_idx;
				rb_addr = r_idx[SLOT_W-1:0];
			end
			default: ra_addr = '0;
		endcase
	end

	always_comb begin
		hw_en = 1'b0;
		hw_addr = pos_q;
		hw_data = cur_q;
		sw_en = 1'b0;
		sw_addr = cur_q.owner;
		sw_data = pos_q;
		if (state_q == S_SRD && !dn_q && pos_q == '0) begin
			hw_en = 1'b1;
			sw_en = 1'b1;
		end else if (state_q == S_SCMP) begin
			if (dn_q) begin
				if (lv || rv) begin
					hw_en = 1'b1;
					hw_data = child;
					sw_en = 1'b1;
					sw_addr = child.owner;
				end else if (moved_q) begin
					hw_en = 1'b1;
					sw_en = 1'b1;
				end
			end else begin
				hw_en = 1'b1;
				sw_en = 1'b1;
				if (pv) begin
					hw_data = ha_q;
					sw_addr = ha_q.owner;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ha_q <= heap_mem[ra_addr];
		hb_q <= heap_mem[rb_addr];
		sm_q <= slot_mem[(state_q == S_IDLE) ? req.data.timer_id : id_q];
		fb_q <= fire_mem[emit_q];
		if (hw_en) begin
			heap_mem[hw_addr] <= hw_data;
		end
		if (sw_en) begin
			slot_mem[sw_addr] <= sw_data;
		end
		if (state_q == S_TCHK && expired) begin
			fire_mem[nfire_q[SLOT_W-1:0]] <= ha_q.owner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			count_q <= '0;
			nfire_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_EOUT) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q <= req.data.action;
						id_q <= req.data.timer_id;
						to_q <= req.data.timeout;
						nfire_q <= '0;
						res_id_q <= '0;
						kind_q <= KIND_DONE;
						case (req.data.action)
							ACT_TICK: begin
								now_q <= now_q + 1'b1;
								state_q <= S_TROOT;
							end
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_WAIT;
							end
							default: state_q <= S_LOOK;
						endcase
					end
				end
				S_LOOK: state_q <= S_CHK;
				S_CHK: begin
					dn_q <= 1'b1;
					moved_q <= 1'b0;
					if ({1'b0, id_q} >= (ID_W+1)'(ID_COUNT)) begin
						kind_q <= KIND_ABSENT;
						state_q <= S_WAIT;
					end else if (act_q == ACT_ADD) begin
						cur_q.expiry <= now_q + TIME_W'(to_q);
						cur_q.owner <= id_q;
						if (known) begin
							pos_q <= sm_q;
							state_q <= S_SRD;
						end else if (count_q >= CNT_W'(HEAP_DEPTH)) begin
							kind_q <= KIND_FULL;
							state_q <= S_WAIT;
						end else begin
							pos_q <= count_q[SLOT_W-1:0];
							count_q <= count_q + 1'b1;
							state_q <= S_SRD;
						end
					end else if (known && count_q != '0) begin
						kind_q <= KIND_FIRED;
						res_id_q <= id_q;
						pos_q <= sm_q;
						state_q <= S_REM;
					end else begin
						kind_q <= KIND_ABSENT;
						state_q <= S_WAIT;
					end
				end
				S_REM: begin
					count_q <= count_q - 1'b1;
					dn_q <= 1'b1;
					moved_q <= 1'b0;
					if ({1'b0, pos_q} < count_q - 1'b1) begin
						state_q <= S_REMW;
					end else begin
						state_q <= after_sift;
					end
				end
				S_REMW: begin
					cur_q <= ha_q;
					state_q <= S_SRD;
				end
				S_SRD: begin
					if (!dn_q && pos_q == '0) begin
						state_q <= after_sift;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (dn_q) begin
						if (lv || rv) begin
							pos_q <= rv ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];
							moved_q <= 1'b1;
							state_q <= S_SRD;
						end else if (moved_q) begin
							state_q <= after_sift;
						end else begin
							dn_q <= 1'b0;
							state_q <= S_SRD;
						end
					end else if (pv) begin
						pos_q <= par_idx;
						state_q <= S_SRD;
					end else begin
						state_q <= after_sift;
					end
				end
				S_TROOT: state_q <= (count_q == '0) ? S_WAIT : S_TCHK;
				S_TCHK: begin
					if (expired) begin
						nfire_q <= nfire_q + 1'b1;
						pos_q <= '0;
						state_q <= S_REM;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_WAITW;
				S_WAITW: begin
					empty_q <= (count_q == '0);
					if (count_q == '0 || root_d[TIME_W-1]) begin
						wait_q <= '0;
					end else if (root_d[TIME_W-1:WAIT_W] != '0) begin
						wait_q <= '1;
					end else begin
						wait_q <= root_d[WAIT_W-1:0];
					end
					emit_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: state_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_q.kind <= single ? kind_q : KIND_FIRED;
						out_q.fired_id <= single ? res_id_q : fb_q;
						out_q.next_wait <= wait_q;
						out_q.queue_empty <= empty_q;
						out_q.last <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q <= emit_q + 1'b1;
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH)) else $error("heap count above depth");
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= CNT_W'(HEAP_DEPTH)) else $error("too many fired timers");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EOUT && out_free && is_last) |=> (state_q == S_IDLE && rsp.valid
		&& rsp.data.last)) else $error("last word not followed by idle");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> (count_q <= $past(count_q) + 1'b1))
		else $error("heap count grew by more than one");
`endif
endmodule
